// ===== hdl/fcs_pkg.sv =====
// Shared types, codes and size constants for the flash command sequencer.
package fcs_pkg;

	// Array geometry (bytes are addressed, words are 16 bits).
	localparam int ADDR_BITS   = 17;
	localparam int SECTOR_BITS = 12;
	localparam int BLOCK_BITS  = 16;
	localparam int WORD_BITS   = ADDR_BITS - 1;

	// Width of the address field on the bus.
	localparam int OFS_W = 17;
	localparam logic [OFS_W-1:0] OFS_MASK = (ADDR_BITS >= OFS_W) ? {OFS_W{1'b1}} :
		OFS_W'((64'd1 << ADDR_BITS) - 64'd1);

	// Word-index masks covering one erase region, clipped to the array.
	localparam logic [WORD_BITS-1:0] SECTOR_MASK = (SECTOR_BITS - 1 >= WORD_BITS) ?
		{WORD_BITS{1'b1}} : WORD_BITS'((64'd1 << (SECTOR_BITS - 1)) - 64'd1);
	localparam logic [WORD_BITS-1:0] BLOCK_MASK = (BLOCK_BITS - 1 >= WORD_BITS) ?
		{WORD_BITS{1'b1}} : WORD_BITS'((64'd1 << (BLOCK_BITS - 1)) - 64'd1);

	// Unlock addresses as byte offsets.
	localparam logic [OFS_W-1:0] UNLOCK_A_OFS = 17'h0aaaa;
	localparam logic [OFS_W-1:0] UNLOCK_B_OFS = 17'h05554;

	// Command codes (low byte of the write data).
	localparam logic [7:0] CMD_UNLOCK1 = 8'haa;
	localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
	localparam logic [7:0] CMD_ERASE   = 8'h80;
	localparam logic [7:0] CMD_ID      = 8'h90;
	localparam logic [7:0] CMD_CFI     = 8'h98;
	localparam logic [7:0] CMD_PROG    = 8'ha0;
	localparam logic [7:0] CMD_CHIP    = 8'h10;
	localparam logic [7:0] CMD_SECTOR  = 8'h30;
	localparam logic [7:0] CMD_BLOCK   = 8'h50;
	localparam logic [7:0] CMD_RESET   = 8'hf0;

	// Command states, reported as mode_now.
	localparam logic [3:0] MODE_READ  = 4'd0;
	localparam logic [3:0] MODE_E1    = 4'd1;
	localparam logic [3:0] MODE_E2    = 4'd2;
	localparam logic [3:0] MODE_E3    = 4'd3;
	localparam logic [3:0] MODE_E4    = 4'd4;
	localparam logic [3:0] MODE_E5    = 4'd5;
	localparam logic [3:0] MODE_QUERY = 4'd6;
	localparam logic [3:0] MODE_PROG  = 4'd7;

	// Result status codes.
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_SEQ     = 2'd1;
	localparam logic [1:0] STAT_BADSIZE = 2'd2;
	localparam logic [1:0] STAT_QUERY   = 2'd3;

	// Access sizes in bytes.
	localparam logic [2:0] SIZE_1 = 3'd1;
	localparam logic [2:0] SIZE_2 = 3'd2;
	localparam logic [2:0] SIZE_4 = 3'd4;

	// Back-end operation kinds.
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_RD1   = 3'd1;
	localparam logic [2:0] OP_RD2   = 3'd2;
	localparam logic [2:0] OP_RD4   = 3'd3;
	localparam logic [2:0] OP_PROG  = 3'd4;
	localparam logic [2:0] OP_ERASE = 3'd5;

	// Queue between front and back.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	// One classified request handed from the front to the back.
	typedef struct packed {
		logic [2:0]           kind;
		logic [WORD_BITS-1:0] word;     // word index, or erase start
		logic [WORD_BITS-1:0] last;     // last word of an erase
		logic [15:0]          data;     // halfword to program
		logic                 hi_byte;  // single-byte read of the upper byte
		logic [1:0]           status;
		logic [3:0]           mode;
	} op_t;

endpackage

// ===== hdl/fcs_front.sv =====
// Front end: accepts bus requests, runs the command state machine, classifies each request.
module fcs_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [39:0]  s_tdata,
	input  logic [0:0]   s_tuser,
	input  logic         q_full,
	input  logic         clearing,
	output logic         push,
	output fcs_pkg::op_t op
);
	import fcs_pkg::*;

	logic [3:0]           state_q;
	logic [3:0]           nxt;
	logic [OFS_W-1:0]     ofs;
	logic [2:0]           size;
	logic [15:0]          wdata;
	logic [7:0]           code;
	logic [WORD_BITS-1:0] wi;
	logic                 is_a;
	logic                 is_b;
	logic                 fail;

	assign ofs   = s_tdata[16:0] & OFS_MASK;
	assign size  = s_tdata[19:17];
	assign wdata = s_tdata[35:20];
	assign code  = wdata[7:0];
	assign wi    = WORD_BITS'(ofs >> 1);
	assign is_a  = (ofs == UNLOCK_A_OFS);
	assign is_b  = (ofs == UNLOCK_B_OFS);

	assign s_tready = !q_full && !clearing;
	assign push     = s_tvalid && s_tready;

	always_comb begin
		nxt        = state_q;
		fail       = 1'b0;
		op.kind    = OP_NONE;
		op.word    = wi;
		op.last    = wi;
		op.data    = wdata;
		op.hi_byte = ofs[0];
		op.status  = STAT_OK;
		if (s_tuser[0]) begin
			if (size != SIZE_2 || ofs[0]) begin
				op.status = STAT_BADSIZE;
			end else if (state_q != MODE_PROG && code == CMD_RESET) begin
				nxt = MODE_READ;
			end else begin
				fail = 1'b1;
				unique case (state_q)
					MODE_READ: begin
						if (is_a && code == CMD_UNLOCK1) begin
							nxt  = MODE_E1;
							fail = 1'b0;
						end
					end
					MODE_E1: begin
						if (is_b && code == CMD_UNLOCK2) begin
							nxt  = MODE_E2;
							fail = 1'b0;
						end
					end
					MODE_E2: begin
						if (is_a && code == CMD_ERASE) begin
							nxt  = MODE_E3;
							fail = 1'b0;
						end else if (is_a && (code == CMD_ID || code == CMD_CFI)) begin
							nxt  = MODE_QUERY;
							fail = 1'b0;
						end else if (is_a && code == CMD_PROG) begin
							nxt  = MODE_PROG;
							fail = 1'b0;
						end
					end
					MODE_E3: begin
						if (is_a && code == CMD_UNLOCK1) begin
							nxt  = MODE_E4;
							fail = 1'b0;
						end
					end
					MODE_E4: begin
						if (is_b && code == CMD_UNLOCK2) begin
							nxt  = MODE_E5;
							fail = 1'b0;
						end
					end
					MODE_E5: begin
						if (code == CMD_CHIP && is_a) begin
							op.kind = OP_ERASE;
							op.word = '0;
							op.last = '1;
							nxt     = MODE_READ;
							fail    = 1'b0;
						end else if (code == CMD_SECTOR) begin
							op.kind = OP_ERASE;
							op.word = wi & ~SECTOR_MASK;
							op.last = wi | SECTOR_MASK;
							nxt     = MODE_READ;
							fail    = 1'b0;
						end else if (code == CMD_BLOCK) begin
							op.kind = OP_ERASE;
							op.word = wi & ~BLOCK_MASK;
							op.last = wi | BLOCK_MASK;
							nxt     = MODE_READ;
							fail    = 1'b0;
						end
					end
					MODE_QUERY: begin
						// Unlock writes are ignored while in query mode.
						if ((is_a && code == CMD_UNLOCK1) || (is_b && code == CMD_UNLOCK2)) begin
							fail = 1'b0;
						end
					end
					MODE_PROG: begin
						op.kind = OP_PROG;
						nxt     = MODE_READ;
						fail    = 1'b0;
					end
					default: begin
					end
				endcase
				if (fail) begin
					nxt       = MODE_READ;
					op.status = STAT_SEQ;
				end
			end
		end else begin
			if (size != SIZE_1 && size != SIZE_2 && size != SIZE_4) begin
				op.status = STAT_BADSIZE;
			end else if ((size == SIZE_2 && ofs[0]) || (size == SIZE_4 && ofs[1:0] != 2'b00)) begin
				op.status = STAT_BADSIZE;
			end else if (state_q == MODE_READ) begin
				if (size == SIZE_1) begin
					op.kind = OP_RD1;
				end else if (size == SIZE_2) begin
					op.kind = OP_RD2;
				end else begin
					op.kind = OP_RD4;
				end
			end else if (state_q == MODE_QUERY) begin
				op.status = STAT_QUERY;
			end else begin
				nxt       = MODE_READ;
				op.status = STAT_SEQ;
			end
		end
		op.mode = nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MODE_READ;
		end else if (push) begin
			state_q <= nxt;
		end
	end

endmodule

// ===== hdl/fcs_queue.sv =====
// Short FIFO of classified requests between the front and the back end.
module fcs_queue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  fcs_pkg::op_t push_op,
	input  logic         pop,
	output logic         head_valid,
	output fcs_pkg::op_t head_op,
	output logic         full
);
	import fcs_pkg::*;

	op_t               slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   count_q;

	assign head_valid = (count_q != '0);
	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head_op    = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/fcs_back.sv =====
// Back end: owns the flash word array and carries out reads, programs and erases.
module fcs_back (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_valid,
	input  fcs_pkg::op_t q_op,
	output logic         q_pop,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [39:0]  m_tdata,
	output logic         clearing
);
	import fcs_pkg::*;

	localparam int NUM_WORDS = 1 << WORD_BITS;

	localparam logic [2:0] BK_CLEAR = 3'd0;
	localparam logic [2:0] BK_IDLE  = 3'd1;
	localparam logic [2:0] BK_RD1   = 3'd2;
	localparam logic [2:0] BK_RD2   = 3'd3;
	localparam logic [2:0] BK_ERASE = 3'd4;

	logic [15:0]          mem [NUM_WORDS];
	logic [15:0]          rdata_q;
	logic                 mem_we;
	logic                 mem_re;
	logic [WORD_BITS-1:0] mem_addr;
	logic [15:0]          mem_wdata;

	logic [2:0]           state_q;
	logic [WORD_BITS-1:0] cnt_q;
	op_t                  op_q;
	op_t                  src;
	logic [15:0]          lo_q;

	logic                 load_out;
	logic [31:0]          out_data;
	logic                 out_vld_q;
	logic [31:0]          out_data_q;
	logic [1:0]           out_stat_q;
	logic [3:0]           out_mode_q;

	assign clearing = (state_q == BK_CLEAR);
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {2'b00, out_mode_q, out_stat_q, out_data_q};
	assign src      = (state_q == BK_IDLE) ? q_op : op_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = cnt_q;
		mem_wdata = 16'hffff;
		q_pop     = 1'b0;
		load_out  = 1'b0;
		out_data  = '0;
		unique case (state_q)
			BK_CLEAR: begin
				mem_we = 1'b1;
			end
			BK_IDLE: begin
				if (q_valid && (!out_vld_q || m_tready)) begin
					q_pop = 1'b1;
					unique case (q_op.kind) inside
						OP_PROG: begin
							mem_we    = 1'b1;
							mem_addr  = q_op.word;
							mem_wdata = q_op.data;
							load_out  = 1'b1;
						end
						OP_RD1, OP_RD2, OP_RD4: begin
							mem_re   = 1'b1;
							mem_addr = q_op.word;
						end
						OP_ERASE: begin
						end
						default: begin
							load_out = 1'b1;
						end
					endcase
				end
			end
			BK_RD1: begin
				if (op_q.kind == OP_RD4) begin
					mem_re   = 1'b1;
					mem_addr = {op_q.word[WORD_BITS-1:1], 1'b1};
				end else begin
					load_out = 1'b1;
					if (op_q.kind == OP_RD1) begin
						out_data = {24'd0, op_q.hi_byte ? rdata_q[15:8] : rdata_q[7:0]};
					end else begin
						out_data = {16'd0, rdata_q};
					end
				end
			end
			BK_RD2: begin
				load_out = 1'b1;
				out_data = {rdata_q, lo_q};
			end
			BK_ERASE: begin
				mem_we   = 1'b1;
				load_out = (cnt_q == op_q.last);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_CLEAR;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				BK_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == '1) begin
						state_q <= BK_IDLE;
					end
				end
				BK_IDLE: begin
					if (q_pop) begin
						if (q_op.kind == OP_RD1 || q_op.kind == OP_RD2 || q_op.kind == OP_RD4) begin
							state_q <= BK_RD1;
						end else if (q_op.kind == OP_ERASE) begin
							cnt_q   <= q_op.word;
							state_q <= BK_ERASE;
						end
					end
				end
				BK_RD1: begin
					state_q <= (op_q.kind == OP_RD4) ? BK_RD2 : BK_IDLE;
				end
				BK_RD2: begin
					state_q <= BK_IDLE;
				end
				BK_ERASE: begin
					if (cnt_q == op_q.last) begin
						state_q <= BK_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			op_q <= q_op;
		end
		if (state_q == BK_RD1) begin
			lo_q <= rdata_q;
		end
		if (load_out) begin
			out_data_q <= out_data;
			out_stat_q <= src.status;
			out_mode_q <= src.mode;
		end
	end

endmodule

// ===== hdl/flash_command_sequencer.sv =====
// Top level of the flash command sequencer: front end, request queue and back end.
//
// Requests arrive on the s_ channel, one bus access each: a read of 1, 2 or 4 bytes,
// or a halfword write that drives the unlock and command sequence. Every request
// gives exactly one response on the m_ channel carrying read data, a status and the
// command state after the request. The front end runs the command state machine and
// classifies each request in the cycle it is accepted; a four-entry queue hands the
// work to the back end, which owns the single-port word array.
// Work per request in the back end: a write or an error response needs no array read,
// a 1- or 2-byte read takes one array read, a 4-byte read two, and an erase writes
// each word it covers (2048, 32768 or 65536 words by default) through the single
// array port. A read passes through the queue slot, the array read register and
// the output register before its response appears.
// After reset the back end fills the whole array with ones, one word per cycle
// (65536 words by default), and s_tready stays low until that is done.
// When the receiver stalls, the response waits in the output register; the front
// keeps accepting requests until the queue is full.
module flash_command_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // address[16:0], access_size[19:17], write_data[35:20]
	input  logic [0:0]  s_tuser,   // cmd[0]: 0 read, 1 write
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // read_data[31:0], status[33:32], mode_now[37:34]
);
	import fcs_pkg::*;

	logic push;
	logic pop;
	logic head_valid;
	logic full;
	logic clearing;
	op_t  push_op;
	op_t  head_op;

	// Front end: command state and classification of each request.
	fcs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (full),
		.clearing (clearing),
		.push     (push),
		.op       (push_op)
	);

	// Queue that lets the front keep going while the back end erases or stalls.
	fcs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_op    (push_op),
		.pop        (pop),
		.head_valid (head_valid),
		.head_op    (head_op),
		.full       (full)
	);

	// Back end: array accesses and the registered response.
	fcs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (head_valid),
		.q_op     (head_op),
		.q_pop    (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.clearing (clearing)
	);

	// A query-mode read response always reports the query state.
	a_query_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[33:32] == STAT_QUERY) |-> (m_tdata[37:34] == MODE_QUERY))
		else $error("query status with a mode other than query");

	// A sequence error always drops back to read mode.
	a_seq_read: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[33:32] == STAT_SEQ) |-> (m_tdata[37:34] == MODE_READ))
		else $error("sequence error without a return to read mode");

	// Data only comes back for successful reads.
	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[31:0] != 32'd0) |-> (m_tdata[33:32] == STAT_OK))
		else $error("nonzero read data with an error status");

	// No request enters the queue while the array is being cleared.
	a_no_push_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !push)
		else $error("request accepted during the clearing pass");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the flash command sequencer: shadow array, stimulus and checks.
`timescale 1ns / 100ps

import fcs_pkg::*;

// What one access should return.
typedef struct {
	logic [31:0] read_data;
	logic [1:0]  status;
	logic [3:0]  mode;
} access_result_t;

// Shadow copy of the flash array and the command state, plus the responses still owed.
class flash_shadow;
	logic [15:0]    words [0:(1 << WORD_BITS) - 1];
	logic [3:0]     mode;
	access_result_t responses_due [$];
	int             errors;

	function new();
		foreach (words[i]) words[i] = 16'hffff;
		mode = MODE_READ;
		errors = 0;
	endfunction

	// Erase the aligned region of 2^bits bytes around ofs, clipped to the array.
	function void fill_ones(longint unsigned ofs, int bits);
		longint unsigned span, base, stop, w;
		span = 64'd1 << bits;
		base = ofs & ~(span - 64'd1);
		stop = base + span;
		if (stop > (64'd1 << ADDR_BITS)) stop = 64'd1 << ADDR_BITS;
		for (w = base >> 1; w < (stop >> 1); w++) words[w] = 16'hffff;
	endfunction

	// A well-formed halfword write: steps the command state machine.
	function logic [1:0] command_step(logic [OFS_W-1:0] ofs, logic [15:0] data);
		logic [7:0] code;
		code = data[7:0];
		if (mode != MODE_PROG && code == CMD_RESET) begin
			mode = MODE_READ;
			return STAT_OK;
		end
		case (mode)
			MODE_READ: if (ofs == UNLOCK_A_OFS && code == CMD_UNLOCK1) begin
				mode = MODE_E1;
				return STAT_OK;
			end
			MODE_E1: if (ofs == UNLOCK_B_OFS && code == CMD_UNLOCK2) begin
				mode = MODE_E2;
				return STAT_OK;
			end
			MODE_E2: if (ofs == UNLOCK_A_OFS) begin
				if (code == CMD_ERASE) begin
					mode = MODE_E3;
					return STAT_OK;
				end
				if (code == CMD_ID || code == CMD_CFI) begin
					mode = MODE_QUERY;
					return STAT_OK;
				end
				if (code == CMD_PROG) begin
					mode = MODE_PROG;
					return STAT_OK;
				end
			end
			MODE_E3: if (ofs == UNLOCK_A_OFS && code == CMD_UNLOCK1) begin
				mode = MODE_E4;
				return STAT_OK;
			end
			MODE_E4: if (ofs == UNLOCK_B_OFS && code == CMD_UNLOCK2) begin
				mode = MODE_E5;
				return STAT_OK;
			end
			MODE_E5: begin
				if (code == CMD_CHIP && ofs == UNLOCK_A_OFS) begin
					fill_ones(0, ADDR_BITS);
					mode = MODE_READ;
					return STAT_OK;
				end
				if (code == CMD_SECTOR) begin
					fill_ones(ofs, SECTOR_BITS);
					mode = MODE_READ;
					return STAT_OK;
				end
				if (code == CMD_BLOCK) begin
					fill_ones(ofs, BLOCK_BITS);
					mode = MODE_READ;
					return STAT_OK;
				end
			end
			MODE_QUERY: if ((ofs == UNLOCK_A_OFS && code == CMD_UNLOCK1) ||
					(ofs == UNLOCK_B_OFS && code == CMD_UNLOCK2)) begin
				return STAT_OK;
			end
			MODE_PROG: begin
				// Programming overwrites the word, even with a reset code in the low byte.
				words[ofs >> 1] = data;
				mode = MODE_READ;
				return STAT_OK;
			end
			default: ;
		endcase
		mode = MODE_READ;
		return STAT_SEQ;
	endfunction

	function void accept_request(bit is_write, logic [16:0] address, logic [2:0] size,
			logic [15:0] data);
		access_result_t   r;
		logic [OFS_W-1:0] ofs, a;
		logic [15:0]      w;
		int               k;
		ofs = address & OFS_MASK;
		r.read_data = '0;
		r.status = STAT_OK;
		if (is_write) begin
			if (size != SIZE_2 || ofs[0]) r.status = STAT_BADSIZE;
			else r.status = command_step(ofs, data);
		end else if (size != SIZE_1 && size != SIZE_2 && size != SIZE_4) begin
			r.status = STAT_BADSIZE;
		end else if ((ofs & OFS_W'(size - 3'd1)) != '0) begin
			r.status = STAT_BADSIZE;
		end else if (mode == MODE_READ) begin
			for (k = 0; k < int'(size); k++) begin
				a = OFS_W'(ofs + k) & OFS_MASK;
				w = words[a >> 1];
				r.read_data[8*k +: 8] = a[0] ? w[15:8] : w[7:0];
			end
		end else if (mode == MODE_QUERY) begin
			r.status = STAT_QUERY;
		end else begin
			mode = MODE_READ;
			r.status = STAT_SEQ;
		end
		r.mode = mode;
		responses_due.push_back(r);
	endfunction

	function void check_response(logic [39:0] beat);
		access_result_t want;
		if (responses_due.size() == 0) begin
			errors++;
			$display("%0t: response %h with no request outstanding", $time, beat);
			return;
		end
		want = responses_due.pop_front();
		if (beat[31:0] !== want.read_data) begin
			errors++;
			$display("%0t: read_data expected %h actual %h", $time, want.read_data, beat[31:0]);
		end
		if (beat[33:32] !== want.status) begin
			errors++;
			$display("%0t: status expected %0d actual %0d", $time, want.status, beat[33:32]);
		end
		if (beat[37:34] !== want.mode) begin
			errors++;
			$display("%0t: mode_now expected %0d actual %0d", $time, want.mode, beat[37:34]);
		end
	endfunction
endclass

module tb;

	// Roughly this many requests are sent before the run winds down.
	localparam int REQUEST_TARGET = 1900;

	// Erases are slow (a chip erase walks every word), so the random part rations them.
	localparam int MAX_CHIP_ERASES   = 1;
	localparam int MAX_BLOCK_ERASES  = 2;
	localparam int MAX_SECTOR_ERASES = 40;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // address[16:0], access_size[19:17], write_data[35:20]
	logic [0:0]  s_tuser;   // cmd[0]: 0 read, 1 write
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // read_data[31:0], status[33:32], mode_now[37:34]

	flash_shadow shadow;

	int sender_idle_pct;
	int receiver_idle_pct;
	int requests_sent;
	int chip_erases;
	int block_erases;
	int sector_erases;

	flash_command_sequencer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs. The limit leaves ample margin over the slowest
	// correct run, including the clearing pass after reset and every erase the stimulus
	// allows.
	initial begin
		#40_000_000;
		$display("flash_command_sequencer regression: fail");
		$finish;
	end

	// Response side: a response is taken at an edge where valid and ready were both high
	// just before the edge; ready for the next cycle is then redrawn from the idle ratio.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) shadow.check_response(m_tdata);
		m_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
	end

	// Offer one request and hold it until the block takes it. A random number of idle
	// cycles goes first, so gaps land on every phase of the back end's work.
	task automatic send_request(input bit is_write, input logic [16:0] address,
			input logic [2:0] size, input logic [15:0] data);
		// The idle ratios swap after a third of the run and drop to zero for the last third.
		if (requests_sent < REQUEST_TARGET / 3) begin
			sender_idle_pct = 34;
			receiver_idle_pct = 66;
		end else if (requests_sent < 2 * REQUEST_TARGET / 3) begin
			sender_idle_pct = 66;
			receiver_idle_pct = 34;
		end else begin
			sender_idle_pct = 0;
			receiver_idle_pct = 0;
		end
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, data, size, address};
		s_tuser <= is_write;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		// Accepted at this edge: predict its response now, in acceptance order.
		shadow.accept_request(is_write, address, size, data);
		requests_sent++;
	endtask

	task automatic write_word(input logic [16:0] address, input logic [15:0] data);
		send_request(1'b1, address, SIZE_2, data);
	endtask

	task automatic read_bytes(input logic [16:0] address, input logic [2:0] size);
		// write_data is ignored on reads, so it carries random bits.
		send_request(1'b0, address, size, 16'($urandom));
	endtask

	// Commands look only at the low byte; the upper byte is random throughout.
	task automatic write_code(input logic [16:0] address, input logic [7:0] code);
		write_word(address, {8'($urandom), code});
	endtask

	task automatic unlock();
		write_code(UNLOCK_A_OFS, CMD_UNLOCK1);
		write_code(UNLOCK_B_OFS, CMD_UNLOCK2);
	endtask

	// Most addresses fall in a few small windows so that programmed words get read back
	// and erases hit them; the windows sit at the bottom, around the first unlock address,
	// just under the middle block boundary and at the top of the array.
	function automatic logic [16:0] pick_address();
		logic [16:0] bases [4] = '{17'h00000, 17'h0aa80, 17'h0ff00, 17'h1ff00};
		if ($urandom_range(0, 9) < 6) return bases[$urandom_range(0, 3)] + 17'($urandom_range(0, 255));
		return 17'($urandom);
	endfunction

	function automatic logic [2:0] pick_read_size();
		case ($urandom_range(0, 2))
			0: return SIZE_1;
			1: return SIZE_2;
			default: return SIZE_4;
		endcase
	endfunction

	task automatic aligned_read();
		logic [2:0] size;
		size = pick_read_size();
		read_bytes(pick_address() & ~17'(size - 3'd1), size);
	endtask

	// A size that a write never allows: anything but two bytes.
	function automatic logic [2:0] pick_bad_write_size();
		logic [2:0] size;
		size = 3'($urandom_range(0, 6));
		return (size >= SIZE_2) ? size + 3'd1 : size;
	endfunction

	// Short hand-picked opener: extreme addresses and sizes, rejected accesses, a program
	// whose data has the reset code in its low byte, query mode with an unlock write that
	// is ignored, a read in the middle of a sequence, and a full chip erase.
	task automatic directed_requests();
		read_bytes(17'h00000, SIZE_1);
		read_bytes(17'h1fffc, SIZE_4);
		read_bytes(17'h00000, 3'd3);
		read_bytes(17'h00002, SIZE_4);
		send_request(1'b1, 17'h00000, SIZE_4, 16'h1234);

		unlock();
		write_code(UNLOCK_A_OFS, CMD_PROG);
		write_word(17'h00002, {8'h12, CMD_RESET});
		read_bytes(17'h00000, SIZE_4);

		unlock();
		write_code(UNLOCK_A_OFS, CMD_CFI);
		read_bytes(17'h00004, SIZE_2);
		write_code(UNLOCK_B_OFS, CMD_UNLOCK2);
		write_code(17'h00000, CMD_RESET);

		write_code(UNLOCK_A_OFS, CMD_UNLOCK1);
		read_bytes(17'h00000, SIZE_2);

		unlock();
		write_code(UNLOCK_A_OFS, CMD_ERASE);
		unlock();
		write_code(UNLOCK_A_OFS, CMD_CHIP);
		chip_erases++;
		read_bytes(17'h00000, SIZE_4);
	endtask

	// One random burst. Most bursts are well-formed command sequences with random content;
	// the rest break a sequence part way or throw fully random requests at the block.
	task automatic random_burst();
		int          pick, n, i;
		logic [16:0] address;
		logic [7:0]  code;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			n = $urandom_range(1, 4);
			for (i = 0; i < n; i++) aligned_read();
		end else if (pick < 50) begin
			// Word program. A rejected write in program mode leaves the mode alone, and a
			// read there breaks the sequence.
			unlock();
			write_code(UNLOCK_A_OFS, CMD_PROG);
			if ($urandom_range(0, 9) == 0) begin
				if ($urandom_range(0, 1)) send_request(1'b1, pick_address() | 17'd1, SIZE_2, 16'($urandom));
				else send_request(1'b1, pick_address(), pick_bad_write_size(), 16'($urandom));
			end
			if ($urandom_range(0, 19) == 0) aligned_read();
			else write_word(pick_address() & ~17'd1, 16'($urandom));
			if ($urandom_range(0, 1)) aligned_read();
		end else if (pick < 60) begin
			unlock();
			write_code(UNLOCK_A_OFS, $urandom_range(0, 1) ? CMD_ID : CMD_CFI);
			n = $urandom_range(1, 4);
			for (i = 0; i < n; i++) begin
				case ($urandom_range(0, 2))
					0: aligned_read();
					1: unlock();
					default: read_bytes(17'($urandom), 3'($urandom));
				endcase
			end
			// Leave query mode by the reset code, by a stray write, or not at all (a reset
			// code at an odd address is rejected and the mode stays).
			case ($urandom_range(0, 3))
				0, 1: write_code(pick_address() & ~17'd1, CMD_RESET);
				2: write_code(pick_address() & ~17'd1, CMD_PROG);
				default: write_code(pick_address() | 17'd1, CMD_RESET);
			endcase
		end else if (pick < 70) begin
			unlock();
			write_code(UNLOCK_A_OFS, CMD_ERASE);
			unlock();
			address = pick_address() & ~17'd1;
			if (chip_erases < MAX_CHIP_ERASES && $urandom_range(0, 9) == 0) begin
				chip_erases++;
				write_code(UNLOCK_A_OFS, CMD_CHIP);
			end else if (block_erases < MAX_BLOCK_ERASES && $urandom_range(0, 9) < 2) begin
				block_erases++;
				write_code(address, CMD_BLOCK);
			end else if (sector_erases < MAX_SECTOR_ERASES && $urandom_range(0, 9) < 8) begin
				sector_erases++;
				write_code(address, CMD_SECTOR);
			end else begin
				// A wrong last step: chip erase away from the unlock address, or some other code.
				if (address == UNLOCK_A_OFS) address = address ^ 17'd2;
				code = $urandom_range(0, 1) ? CMD_CHIP : 8'($urandom);
				if (code == CMD_SECTOR || code == CMD_BLOCK) code = CMD_CHIP;
				write_code(address, code);
			end
			read_bytes(address & ~17'd3, SIZE_4);
		end else if (pick < 85) begin
			// A broken erase sequence: one to five good steps, then something out of place.
			n = $urandom_range(1, 5);
			for (i = 0; i < n; i++) begin
				case (i)
					0, 3: write_code(UNLOCK_A_OFS, CMD_UNLOCK1);
					2: write_code(UNLOCK_A_OFS, CMD_ERASE);
					default: write_code(UNLOCK_B_OFS, CMD_UNLOCK2);
				endcase
			end
			case ($urandom_range(0, 3))
				0: aligned_read();
				1: write_code(pick_address() & ~17'd1, CMD_RESET);
				2: begin
					code = 8'($urandom);
					if (code == CMD_SECTOR || code == CMD_BLOCK || code == CMD_CHIP) code = CMD_UNLOCK2;
					write_code(pick_address() & ~17'd1, code);
				end
				default: begin
					send_request(1'b1, pick_address(), pick_bad_write_size(), 16'($urandom));
					write_code(pick_address() & ~17'd1, CMD_RESET);
				end
			endcase
		end else begin
			// Fully random request. An unplanned erase code is kept out of the last erase
			// step so that the slow erases stay within their ration.
			address = 17'($urandom);
			code = 8'($urandom);
			if (shadow.mode == MODE_E5) code = CMD_RESET;
			send_request(1'($urandom), address, 3'($urandom), {8'($urandom), code});
		end
	endtask

	initial begin
		shadow = new();
		requests_sent = 0;
		chip_erases = 0;
		block_erases = 0;
		sector_erases = 0;
		sender_idle_pct = 34;
		receiver_idle_pct = 66;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// The block clears its array after reset with s_tready low; send_request simply
		// waits for the handshake.
		directed_requests();
		while (requests_sent < REQUEST_TARGET) random_burst();
		s_tvalid <= 1'b0;

		// Drain: every response must come back, then a short quiet spell catches extras.
		while (shadow.responses_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (shadow.errors == 0 && shadow.responses_due.size() == 0) begin
			$display("flash_command_sequencer regression: pass");
		end else begin
			$display("flash_command_sequencer regression: fail");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/fcs_pkg.sv
hdl/fcs_front.sv
hdl/fcs_queue.sv
hdl/fcs_back.sv
hdl/flash_command_sequencer.sv
tb/sv/tb.sv
